// ===== src/rrbp_pkg.sv =====
// ----------------------------------------------------------------------------
// rrbp_pkg
// shared types and constants for the round-robin backend picker
// ----------------------------------------------------------------------------
package rrbp_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_PICK   = 3'd2;
    localparam logic [2:0] OP_SORT   = 3'd3;
    localparam logic [2:0] OP_UPDATE = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_NONEWR   = 3'd4;

    // one table entry
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] load;
        logic        wr;
    } entry_t;

    // commands broadcast from the sequencer to every cell
    typedef struct packed {
        logic             load_en;    // write one entry at wr_idx
        logic [IDX_W-1:0] wr_idx;
        entry_t           wr_data;
        logic             sort_step;  // odd-even transposition step
        logic             sort_odd;   // pair phase
        logic [CNT_W-1:0] count;      // live entries
    } cell_ctrl_t;

endpackage

// ===== src/rrbp_cell.sv =====
// ----------------------------------------------------------------------------
// rrbp_cell
// one table slot; swaps with its lower or upper neighbor during a sort step
// ----------------------------------------------------------------------------
module rrbp_cell
(
    input  logic                clk,
    input  logic [rrbp_pkg::IDX_W-1:0] my_idx,
    input  rrbp_pkg::cell_ctrl_t ctrl,
    input  rrbp_pkg::entry_t    lower,   // neighbor at index - 1
    input  rrbp_pkg::entry_t    upper,   // neighbor at index + 1
    output rrbp_pkg::entry_t    entry
);
    import rrbp_pkg::*;

    entry_t          entry_reg;
    entry_t          entry_next;
    logic [CNT_W:0]  pos;
    logic            pair_lo;
    logic            pair_hi;

    assign pos   = {1'b0, {1'b0, my_idx}};
    assign entry = entry_reg;

    // cell at index k pairs up with k+1 when k parity matches the phase
    always_comb
    begin
        pair_lo = (my_idx[0] == ctrl.sort_odd) && (pos + 1 < {1'b0, ctrl.count});
        pair_hi = (my_idx[0] != ctrl.sort_odd) && (my_idx != '0)
                  && (pos < {1'b0, ctrl.count});
    end

    // next entry: explicit write, or compare-swap with neighbor
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load_en && ctrl.wr_idx == my_idx)
        begin
            entry_next = ctrl.wr_data;
        end
        else if (ctrl.sort_step)
        begin
            if (pair_lo && $signed(entry_reg.load) > $signed(upper.load))
                entry_next = upper;
            else if (pair_hi && $signed(lower.load) > $signed(entry_reg.load))
                entry_next = lower;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== src/round_robin_backend_picker_unit.sv =====
// ----------------------------------------------------------------------------
// round_robin_backend_picker_unit
// server table with round-robin pick, delete, update and stable load sort
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  s_axis   in   tdata: operation, server_id, load, writable
//  m_axis   out  tdata: status, picked_id
//
//  add: written into the next free slot as the beat is taken; delete/update:
//  scan one cell per cycle; pick: one try per cycle; sort: one step of the
//  odd-even cell row per live entry.
//  one item at a time; the input is taken again once the sequencer is idle,
//  and a finished beat waits until the result register is empty or being
//  drained. reset clears count, pointer and control; the table itself
//  holds no reset. a stalled m_axis holds its beat.
// ----------------------------------------------------------------------------
module round_robin_backend_picker_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // operation[2:0], server_id[18:3], load[50:19], writable[51]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // status[2:0], picked_id[18:3]
);
    import rrbp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_PICK = 5'b00100,
        S_SORT = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [2:0]       op_reg, op_next;
    logic [15:0]      id_reg, id_next;
    logic [31:0]      ld_reg, ld_next;
    logic             wr_reg, wr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [2:0]       status_reg, status_next;
    logic [15:0]      pick_reg, pick_next;
    logic [2:0]       out_status_reg, out_status_next;
    logic [15:0]      out_pick_reg, out_pick_next;
    logic             oval_reg, oval_next;
    cell_ctrl_t       ctrl;
    entry_t           cells [CAPACITY];
    entry_t           lows  [CAPACITY];
    entry_t           ups   [CAPACITY];
    entry_t           cur;
    logic [IDX_W-1:0] step_idx;
    logic [IDX_W-1:0] ptr_idx;
    logic [IDX_W-1:0] last_idx;
    logic             in_fire;
    logic [CNT_W-1:0] n_left;

    // the cell row
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            assign lows[g] = (g == 0) ? cells[g] : cells[(g + CAPACITY - 1) % CAPACITY];
            assign ups[g]  = (g == CAPACITY - 1) ? cells[g] : cells[(g + 1) % CAPACITY];
            rrbp_cell u_cell
            (
                .clk    (clk),
                .my_idx (IDX_W'(g)),
                .ctrl   (ctrl),
                .lower  (lows[g]),
                .upper  (ups[g]),
                .entry  (cells[g])
            );
        end
    endgenerate

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = oval_reg;
    assign m_axis_tdata  = {5'd0, out_pick_reg, out_status_reg};
    assign step_idx      = step_reg[IDX_W-1:0];
    assign ptr_idx       = ptr_reg[IDX_W-1:0];
    assign last_idx      = IDX_W'(count_reg - 1'b1);
    assign cur           = cells[state_reg == S_PICK ? ptr_idx : step_idx];
    assign n_left        = count_reg - 1'b1;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        ld_next     = ld_reg;
        wr_next     = wr_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        step_next   = step_reg;
        status_next = status_reg;
        pick_next   = pick_reg;
        out_status_next = out_status_reg;
        out_pick_next   = out_pick_reg;
        oval_next   = oval_reg && !m_axis_tready;
        ctrl        = '0;
        ctrl.count  = count_reg;
        ctrl.wr_idx = step_idx;
        ctrl.sort_odd = step_reg[0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next     = s_axis_tdata[2:0];
                    id_next     = s_axis_tdata[18:3];
                    ld_next     = s_axis_tdata[50:19];
                    wr_next     = s_axis_tdata[51];
                    step_next   = '0;
                    status_next = ST_OK;
                    pick_next   = '0;
                    state_next  = S_DONE;
                    case (s_axis_tdata[2:0])
                        OP_ADD:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                                status_next = ST_FULL;
                            else
                            begin
                                ctrl.load_en = 1'b1;
                                ctrl.wr_idx  = count_reg[IDX_W-1:0];
                                ctrl.wr_data = '{id: s_axis_tdata[18:3], load: '0,
                                                 wr: s_axis_tdata[51]};
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        OP_DELETE, OP_UPDATE:
                        begin
                            if (count_reg == '0)
                                status_next = ST_NOTFOUND;
                            else
                                state_next = S_SCAN;
                        end
                        OP_PICK:
                        begin
                            if (count_reg == '0)
                                status_next = ST_EMPTY;
                            else
                            begin
                                status_next = ST_NONEWR;
                                if (ptr_reg >= count_reg)
                                    ptr_next = '0;
                                state_next = S_PICK;
                            end
                        end
                        OP_SORT:
                        begin
                            if (count_reg == '0)
                                status_next = ST_EMPTY;
                            else
                                state_next = S_SORT;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (cur.id == id_reg)
                begin
                    ctrl.load_en = 1'b1;
                    if (op_reg == OP_UPDATE)
                        ctrl.wr_data = '{id: cur.id, load: ld_reg, wr: wr_reg};
                    else
                    begin
                        ctrl.wr_data = cells[last_idx];
                        count_next   = n_left;
                        if (n_left == '0)
                            ptr_next = '0;
                        else if (ptr_reg >= n_left)
                            ptr_next = n_left - 1'b1;
                    end
                    state_next = S_DONE;
                end
                else if (step_reg + 1'b1 >= count_reg)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            S_PICK:
            begin
                if (ptr_reg + 1'b1 >= count_reg)
                    ptr_next = '0;
                else
                    ptr_next = ptr_reg + 1'b1;
                if (cur.wr)
                begin
                    // pointer rests one past the chosen slot, unwrapped
                    ptr_next    = ptr_reg + 1'b1;
                    status_next = ST_OK;
                    pick_next   = cur.id;
                    state_next  = S_DONE;
                end
                else if (step_reg + 1'b1 >= count_reg)
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = S_DONE;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            S_SORT:
            begin
                ctrl.sort_step = 1'b1;
                if (step_reg + 1'b1 >= count_reg)
                    state_next = S_DONE;
                else
                    step_next = step_reg + 1'b1;
            end
            S_DONE:
            begin
                // hand the beat to the result register
                if (!oval_reg || m_axis_tready)
                begin
                    oval_next       = 1'b1;
                    out_status_next = status_reg;
                    out_pick_next   = pick_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        ld_reg     <= ld_next;
        wr_reg     <= wr_next;
        step_reg   <= step_next;
        status_reg <= status_next;
        pick_reg   <= pick_next;
        out_status_reg <= out_status_next;
        out_pick_reg   <= out_pick_next;
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY)) else $error("entry count beyond capacity");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == S_IDLE) else $error("input taken while busy");
    a_pick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_status_reg != ST_OK |-> out_pick_reg == '0)
        else $error("picked id set on failure");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready) else $error("second item taken at once");
`endif

endmodule

// ===== test/round_robin_backend_picker_unit_tb.sv =====
// ----------------------------------------------------------------------------
// round_robin_backend_picker_unit_tb
// streams add, delete, pick, sort and update beats into the server table,
// keeps a shadow copy of the table, and checks every result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module round_robin_backend_picker_unit_tb;

    import rrbp_pkg::*;

    // shadow table and expected result beats
    class picker_scoreboard;
        logic [15:0] ids[CAPACITY];
        logic [31:0] loads[CAPACITY];
        logic        wrs[CAPACITY];
        int          count;
        int          ptr;
        logic [2:0]  exp_status[$];
        logic [15:0] exp_picked[$];
        int          errors;

        function new();
            count  = 0;
            ptr    = 0;
            errors = 0;
        endfunction

        function int find_id(logic [15:0] id);
            for (int i = 0; i < count; i++)
                if (ids[i] == id)
                    return i;
            return count;
        endfunction

        // apply one accepted command to the shadow table
        function void note_command(logic [2:0] op, logic [15:0] id, logic [31:0] ld,
                                   logic wr);
            logic [2:0]  st;
            logic [15:0] pk;
            int          i;
            int          j;
            logic [15:0] kid;
            logic [31:0] kld;
            logic        kwr;
            st = ST_OK;
            pk = 16'd0;
            case (op)
                OP_ADD:
                begin
                    if (count >= CAPACITY)
                        st = ST_FULL;
                    else
                    begin
                        ids[count] = id;
                        loads[count] = 32'd0;
                        wrs[count] = wr;
                        count++;
                    end
                end
                OP_DELETE:
                begin
                    i = find_id(id);
                    if (i >= count)
                        st = ST_NOTFOUND;
                    else
                    begin
                        ids[i] = ids[count-1];
                        loads[i] = loads[count-1];
                        wrs[i] = wrs[count-1];
                        count--;
                        if (count > 0 && ptr >= count)
                            ptr = count - 1;
                        else if (count == 0)
                            ptr = 0;
                    end
                end
                OP_PICK:
                begin
                    if (count == 0)
                        st = ST_EMPTY;
                    else
                    begin
                        st = ST_NONEWR;
                        for (j = 0; j < count; j++)
                        begin
                            if (ptr >= count)
                                ptr = 0;
                            i = ptr;
                            ptr++;
                            if (wrs[i])
                            begin
                                st = ST_OK;
                                pk = ids[i];
                                break;
                            end
                        end
                    end
                end
                OP_SORT:
                begin
                    if (count == 0)
                        st = ST_EMPTY;
                    else
                        for (i = 1; i < count; i++)
                        begin
                            kid = ids[i];
                            kld = loads[i];
                            kwr = wrs[i];
                            j = i;
                            while (j > 0 && $signed(loads[j-1]) > $signed(kld))
                            begin
                                ids[j] = ids[j-1];
                                loads[j] = loads[j-1];
                                wrs[j] = wrs[j-1];
                                j--;
                            end
                            ids[j] = kid;
                            loads[j] = kld;
                            wrs[j] = kwr;
                        end
                end
                OP_UPDATE:
                begin
                    i = find_id(id);
                    if (i >= count)
                        st = ST_NOTFOUND;
                    else
                    begin
                        loads[i] = ld;
                        wrs[i] = wr;
                    end
                end
                default: ;
            endcase
            exp_status.push_back(st);
            exp_picked.push_back(pk);
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(logic [23:0] data);
            logic [2:0]  st;
            logic [15:0] pk;
            if (exp_status.size() == 0)
            begin
                $display("%0t: unexpected result beat, actual %h", $time, data);
                errors++;
                return;
            end
            st = exp_status.pop_front();
            pk = exp_picked.pop_front();
            if (data[2:0] !== st)
            begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, st, data[2:0]);
                errors++;
            end
            if (data[18:3] !== pk)
            begin
                $display("%0t: picked_id mismatch, expected %h actual %h",
                         $time, pk, data[18:3]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;    // operation[2:0], server_id[18:3], load[50:19], writable[51]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // status[2:0], picked_id[18:3]

    picker_scoreboard board;
    bit               quiet;      // no idling in the last part
    int               idle_cycles;
    bit               timed_out;
    logic [15:0]      id_pool[8];

    round_robin_backend_picker_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // send one command beat, with an optional random gap before it
    task automatic send_command(logic [2:0] op, logic [15:0] id, logic [31:0] ld,
                                logic wr);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, wr, ld, id, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_command(op, id, ld, wr);
    endtask

    // random command, mostly on ids from a small fixed pool
    task automatic send_random();
        logic [2:0]  op;
        logic [15:0] id;
        logic [31:0] ld;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 22)
            op = OP_ADD;
        else if (r < 38)
            op = OP_DELETE;
        else if (r < 62)
            op = OP_PICK;
        else if (r < 70)
            op = OP_SORT;
        else if (r < 97)
            op = OP_UPDATE;
        else
            op = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 9) < 8)
            id = id_pool[$urandom_range(0, 7)];
        else
            id = 16'($urandom);
        case ($urandom_range(0, 4))
            0: ld = 32'($urandom_range(0, 7));
            1: ld = -32'($urandom_range(0, 7));
            2: ld = 32'h8000_0000;
            3: ld = 32'h7fff_ffff;
            default: ld = $urandom;
        endcase
        send_command(op, id, ld, 1'($urandom));
    endtask

    // result side: random stalls, checks each beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
        end
    end

    initial
    begin
        int burst;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            if (!quiet)
            begin
                burst = $urandom_range(1, 6);
                m_axis_tready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("round_robin_backend_picker_unit_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        board         = new();
        quiet         = 1'b0;
        idle_cycles   = 0;
        timed_out     = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        id_pool = '{16'h0000, 16'hffff, 16'h0001, 16'h8000, 16'h1234, 16'h00ff,
                    16'h0001, 16'haaaa};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table cases, fill to full, extremes of load
        send_command(OP_PICK, 16'h0000, 32'd0, 1'b0);
        send_command(OP_SORT, 16'h0000, 32'd0, 1'b0);
        send_command(OP_DELETE, 16'hffff, 32'd0, 1'b0);
        send_command(OP_UPDATE, 16'hffff, 32'd0, 1'b1);
        for (int k = 0; k < CAPACITY; k++)
            send_command(OP_ADD, (k == 3) ? 16'hffff : 16'(k % 5), 32'd0, 1'(k > 12));
        send_command(OP_ADD, 16'h5555, 32'd0, 1'b1);
        send_command(OP_UPDATE, 16'h0001, 32'h8000_0000, 1'b1);
        send_command(OP_UPDATE, 16'hffff, 32'h7fff_ffff, 1'b0);
        send_command(OP_SORT, 16'h0000, 32'hffff_ffff, 1'b1);
        send_command(OP_PICK, 16'h0000, 32'd0, 1'b0);
        send_command(3'd7, 16'hffff, 32'hffff_ffff, 1'b1);
        send_command(OP_DELETE, 16'h0001, 32'd0, 1'b0);

        // random body
        for (int k = 0; k < 1850; k++)
        begin
            if (k == 1600)
                quiet = 1'b1;
            send_random();
        end
        s_axis_tvalid <= 1'b0;

        // drain
        while (board.exp_status.size() != 0)
            @(posedge clk);
        repeat (2 * CAPACITY + 10) @(posedge clk);
        if (board.errors == 0)
            $display("round_robin_backend_picker_unit_tb: done, clean");
        else
            $display("round_robin_backend_picker_unit_tb: done, errors");
        $finish;
    end

endmodule
